// ===== rtl/svt_pkg.sv =====
package svt_pkg;

  // table geometry
  localparam int DEF_CAPACITY = 16;
  localparam int VAL_W        = 32;
  localparam int REQ_W        = 2;
  localparam int SIZE_W       = 31;
  localparam int STS_W        = 3;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_DUMP    = 2'd3
  } req_t;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STS_W-1:0] STS_EMPTY     = 3'd3;
  localparam logic [STS_W-1:0] STS_NONE      = 3'd4;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP,
    ST_RELEASE
  } state_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_RELEASE,
    OP_ROTATE
  } cell_op_t;

  // command broadcast to the row of cells
  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W:0]   range_lo;
    logic signed [VAL_W:0]   range_hi;
  } cell_cmd_t;

  // where a cell sits relative to the fill count
  typedef struct packed {
    logic occ;   // cell holds an entry
    logic tail;  // first free cell
    logic wrap;  // last held cell
  } cell_pos_t;

endpackage

// ===== rtl/sorted_value_table.sv =====
// channel   direction  handshake            beat
// in_       input      start & !busy        req_type, value, range_start, range_size
// out_      output     out_valid, 1 cycle   status, item_value, freed_count,
//                                           entry_count, last
//
// insert and delete leave busy low; the result shows the next cycle.
// release first compares and overwrites, then gives the count of the freed cells.
// dump of n entries keeps busy high while it gives one result per entry, rotating the row of
// cells through the head cell; busy drops in the cycle the last beat is shown.
// rst_n is synchronous and clears the fill count and control; entries are not cleared.
// the receiver cannot stall: every result is taken in the cycle it is shown.
module sorted_value_table #(
  parameter int CAPACITY = svt_pkg::DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [svt_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [svt_pkg::VAL_W-1:0]   in_value,
  input  logic signed [svt_pkg::VAL_W-1:0]   in_range_start,
  input  logic [svt_pkg::SIZE_W-1:0]         in_range_size,
  output logic                               out_valid,
  output logic [svt_pkg::STS_W-1:0]          out_status,
  output logic signed [svt_pkg::VAL_W-1:0]   out_item_value,
  output logic [CNT_W-1:0]                   out_freed_count,
  output logic [CNT_W-1:0]                   out_entry_count,
  output logic                               out_last
);

  svt_pkg::state_t                   state_r;
  svt_pkg::state_t                   state_nxt;
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic [CNT_W-1:0]                  rem_r;
  logic [CNT_W-1:0]                  rem_nxt;
  logic [CAPACITY-1:0]               hit_r;
  logic [CAPACITY-1:0]               hit_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [svt_pkg::STS_W-1:0]         out_status_r;
  logic [svt_pkg::STS_W-1:0]         out_status_nxt;
  logic signed [svt_pkg::VAL_W-1:0]  out_item_r;
  logic signed [svt_pkg::VAL_W-1:0]  out_item_nxt;
  logic [CNT_W-1:0]                  out_freed_r;
  logic [CNT_W-1:0]                  out_freed_nxt;
  logic [CNT_W-1:0]                  out_entry_r;
  logic [CNT_W-1:0]                  out_entry_nxt;
  logic                              out_last_r;
  logic                              out_last_nxt;

  logic                              accept;
  logic                              full;
  logic                              empty;
  logic [CNT_W-1:0]                  freed;
  svt_pkg::req_t                     req;
  svt_pkg::cell_op_t                 cell_op;
  svt_pkg::cell_cmd_t                cmd;
  svt_pkg::cell_pos_t                pos [CAPACITY];
  logic signed [svt_pkg::VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY:0]                 match;
  logic [CAPACITY-1:0]               rel_hit;

  assign req      = svt_pkg::req_t'(in_req_type);
  assign accept   = start && !busy;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign freed    = CNT_W'($countones(hit_r));
  assign match[0] = 1'b0;

  // broadcast command and release bounds
  assign cmd.op       = cell_op;
  assign cmd.value    = in_value;
  assign cmd.range_lo = {in_range_start[svt_pkg::VAL_W-1], in_range_start};
  assign cmd.range_hi = {in_range_start[svt_pkg::VAL_W-1], in_range_start} +
                        {2'b00, in_range_size};

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign pos[i].occ  = (CNT_W'(i) < count_r);
    assign pos[i].tail = (count_r == CNT_W'(i));
    assign pos[i].wrap = (count_r == CNT_W'(i + 1));

    svt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos[i]),
      .left_val  ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val ((i == CAPACITY - 1) ? '0 : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .head_val  (cell_val[0]),
      .match_in  (match[i]),
      .match_out (match[i+1]),
      .rel_hit   (rel_hit[i]),
      .val       (cell_val[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svt_pkg::ST_IDLE: begin
        if (accept && req == svt_pkg::REQ_RELEASE) begin
          state_nxt = svt_pkg::ST_RELEASE;
        end else if (accept && req == svt_pkg::REQ_DUMP && !empty) begin
          state_nxt = svt_pkg::ST_DUMP;
        end
      end
      svt_pkg::ST_DUMP: begin
        if (rem_r == CNT_W'(1)) begin
          state_nxt = svt_pkg::ST_IDLE;
        end
      end
      svt_pkg::ST_RELEASE: begin
        state_nxt = svt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = svt_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs: busy and cell operation
  always_comb begin
    busy    = 1'b1;
    cell_op = svt_pkg::OP_HOLD;
    case (state_r)
      svt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (req)
            svt_pkg::REQ_INSERT:  cell_op = full ? svt_pkg::OP_HOLD : svt_pkg::OP_INSERT;
            svt_pkg::REQ_DELETE:  cell_op = svt_pkg::OP_DELETE;
            svt_pkg::REQ_RELEASE: cell_op = svt_pkg::OP_RELEASE;
            default:              cell_op = svt_pkg::OP_HOLD;
          endcase
        end
      end
      svt_pkg::ST_DUMP: begin
        cell_op = svt_pkg::OP_ROTATE;
      end
      default: begin
        cell_op = svt_pkg::OP_HOLD;
      end
    endcase
  end

  // count, release hits and result beat
  always_comb begin
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = svt_pkg::STS_OK;
    out_item_nxt   = '0;
    out_freed_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      svt_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            svt_pkg::REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = svt_pkg::STS_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            svt_pkg::REQ_DELETE: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = svt_pkg::STS_EMPTY;
              end else if (!match[CAPACITY]) begin
                out_status_nxt = svt_pkg::STS_NOT_FOUND;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            svt_pkg::REQ_RELEASE: begin
              hit_nxt = rel_hit;
            end
            default: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = svt_pkg::STS_EMPTY;
              end else begin
                rem_nxt = count_r;
              end
            end
          endcase
        end
      end
      svt_pkg::ST_DUMP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = cell_val[0];
        out_last_nxt  = (rem_r == CNT_W'(1));
        rem_nxt       = rem_r - CNT_W'(1);
      end
      svt_pkg::ST_RELEASE: begin
        out_valid_nxt  = 1'b1;
        out_freed_nxt  = freed;
        out_status_nxt = (freed != '0) ? svt_pkg::STS_OK : svt_pkg::STS_NONE;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    out_entry_nxt = count_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svt_pkg::ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_freed_r  <= out_freed_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_value  = out_item_r;
  assign out_freed_count = out_freed_r;
  assign out_entry_count = out_entry_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/svt_cell.sv =====
module svt_cell (
  input  logic                            clk,
  input  svt_pkg::cell_cmd_t              cmd,
  input  svt_pkg::cell_pos_t              pos,
  input  logic signed [svt_pkg::VAL_W-1:0] left_val,
  input  logic signed [svt_pkg::VAL_W-1:0] right_val,
  input  logic signed [svt_pkg::VAL_W-1:0] head_val,
  input  logic                            match_in,
  output logic                            match_out,
  output logic                            rel_hit,
  output logic signed [svt_pkg::VAL_W-1:0] val
);

  logic signed [svt_pkg::VAL_W-1:0] val_r;
  logic signed [svt_pkg::VAL_W-1:0] val_nxt;
  logic signed [svt_pkg::VAL_W:0]   val_ext;
  logic                             hit;

  assign val     = val_r;
  assign val_ext = {val_r[svt_pkg::VAL_W-1], val_r};

  // compare against the broadcast value, then pass the match on; flag a hit in the release range
  always_comb begin
    if (cmd.op == svt_pkg::OP_INSERT) begin
      hit = pos.occ && (val_r >= cmd.value);
    end else begin
      hit = pos.occ && (val_r == cmd.value);
    end
    match_out = match_in | hit;
    rel_hit   = pos.occ && (cmd.op == svt_pkg::OP_RELEASE) &&
                (val_ext >= cmd.range_lo) && (val_ext < cmd.range_hi);
  end

  // next entry value
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      svt_pkg::OP_INSERT: begin
        if (match_in && (pos.occ || pos.tail)) begin
          val_nxt = left_val;
        end else if (!match_in && (hit || pos.tail)) begin
          val_nxt = cmd.value;
        end
      end
      svt_pkg::OP_DELETE: begin
        if (match_out && pos.occ) begin
          val_nxt = right_val;
        end
      end
      svt_pkg::OP_RELEASE: begin
        if (rel_hit) begin
          val_nxt = '1;
        end
      end
      svt_pkg::OP_ROTATE: begin
        if (pos.occ) begin
          val_nxt = pos.wrap ? head_val : right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
